>>> src/kvap_pkg.sv
// ----------------------------------------------------------------------------
// kvap_pkg
// Shared types and codes of the key/value attribute parser: result kinds,
// one result record, the bundle of results that one character produces and the parser state.
// ----------------------------------------------------------------------------
package kvap_pkg;

    // result kinds
    localparam logic [1:0] K_CHAR    = 2'd0;
    localparam logic [1:0] K_ACCEPT  = 2'd1;
    localparam logic [1:0] K_DISCARD = 2'd2;
    localparam logic [1:0] K_DONE    = 2'd3;

    // most results one character can cause
    localparam int RES_MAX = 3;

    // one result
    typedef struct packed {
        logic [1:0] kind;
        logic       key_id;
        logic [7:0] ch;
    } t_res;

    // all results of one character, slot 0 first
    typedef struct packed {
        logic [1:0]               cnt;
        t_res [RES_MAX-1:0]       res;
    } t_bundle;

    // parser state
    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] key_pos;
        logic       lab_match;
        logic       col_match;
        logic       cur_key;
        logic       nonempty;
    } t_pst;

endpackage

>>> src/kvap_if.sv
// ----------------------------------------------------------------------------
// kvap_in_if / kvap_out_if
// Valid/ready channels of the parser: characters in, results out.
// ----------------------------------------------------------------------------
interface kvap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface kvap_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       key_id;
    logic [7:0] out_char;
    logic       last_result;

    modport source (output valid, output kind, output key_id, output out_char,
                    output last_result, input ready);
    modport sink   (input valid, input kind, input key_id, input out_char,
                    input last_result, output ready);
endinterface

>>> src/kvap_front.sv
// ----------------------------------------------------------------------------
// kvap_front
// Parser front end: takes one character per cycle while the queue has room,
// steps the parse state and pushes its bundle of results into the queue.
// ----------------------------------------------------------------------------
module kvap_front
    import kvap_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    kvap_in_if.sink          i_in,
    input  logic             i_q_ready,
    output logic             o_push,
    output t_bundle          o_bundle
);

    // parse phases
    localparam logic [2:0] PH_KEY_SPACE   = 3'd0;
    localparam logic [2:0] PH_KEY         = 3'd1;
    localparam logic [2:0] PH_EQ_SPACE    = 3'd2;
    localparam logic [2:0] PH_VALUE_SPACE = 3'd3;
    localparam logic [2:0] PH_QUOTED      = 3'd4;
    localparam logic [2:0] PH_ESCAPED     = 3'd5;
    localparam logic [2:0] PH_BARE        = 3'd6;
    localparam logic [2:0] PH_STOPPED     = 3'd7;

    // characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic [7:0] WORD_LABEL [5] = '{8'h6C, 8'h61, 8'h62, 8'h65, 8'h6C};
    localparam logic [7:0] WORD_COLOR [5] = '{8'h63, 8'h6F, 8'h6C, 8'h6F, 8'h72};

    localparam t_pst PST_RESET = '{phase: PH_KEY_SPACE, key_pos: 3'd0, lab_match: 1'b1,
                                   col_match: 1'b1, cur_key: 1'b0, nonempty: 1'b0};

    // outcome of one look at the character
    typedef struct packed {
        t_pst st;
        logic again;
        logic emit;
        t_res res;
    } t_hstep;

    function automatic logic is_ws(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_FF;
    endfunction

    function automatic logic is_keych(logic [7:0] c);
        return c > CH_SPACE && c < CH_DEL && c != CH_QUOTE && c != CH_EQ;
    endfunction

    // advance the key match by one character
    function automatic t_pst key_char(t_pst s, logic [7:0] c);
        t_pst r;
        r = s;
        if (s.key_pos < 3'd5) begin
            if (c != WORD_LABEL[s.key_pos]) r.lab_match = 1'b0;
            if (c != WORD_COLOR[s.key_pos]) r.col_match = 1'b0;
        end else begin
            r.lab_match = 1'b0;
            r.col_match = 1'b0;
        end
        if (s.key_pos < 3'd7) r.key_pos = s.key_pos + 3'd1;
        return r;
    endfunction

    // one parse step in the current phase
    function automatic t_hstep handle(t_pst s, logic [7:0] c, logic eot);
        t_hstep h;
        h.st         = s;
        h.again      = 1'b0;
        h.emit       = 1'b0;
        h.res.kind   = K_DISCARD;
        h.res.key_id = s.cur_key;
        h.res.ch     = 8'h00;
        unique case (s.phase)
            PH_KEY_SPACE: begin
                if (!is_ws(c)) begin
                    if (is_keych(c)) begin
                        h.st           = PST_RESET;
                        h.st           = key_char(h.st, c);
                        h.st.phase     = PH_KEY;
                        h.st.nonempty  = s.nonempty;
                    end else begin
                        h.emit     = 1'b1;
                        h.st.phase = PH_STOPPED;
                    end
                end
            end
            PH_KEY: begin
                if (is_keych(c)) begin
                    h.st = key_char(s, c);
                end else if (s.key_pos == 3'd5 && (s.lab_match || s.col_match)) begin
                    h.st.cur_key = s.col_match;
                    h.st.phase   = PH_EQ_SPACE;
                    h.again      = 1'b1;
                end else begin
                    h.emit     = 1'b1;
                    h.st.phase = PH_STOPPED;
                end
            end
            PH_EQ_SPACE: begin
                if (!is_ws(c)) begin
                    if (c == CH_EQ) begin
                        h.st.phase = PH_VALUE_SPACE;
                    end else begin
                        h.emit     = 1'b1;
                        h.st.phase = PH_STOPPED;
                    end
                end
            end
            PH_VALUE_SPACE: begin
                if (!is_ws(c)) begin
                    h.st.nonempty = 1'b0;
                    if (c == CH_QUOTE) begin
                        h.st.phase = PH_QUOTED;
                    end else if (is_keych(c)) begin
                        h.emit        = 1'b1;
                        h.res.kind    = K_CHAR;
                        h.res.ch      = c;
                        h.st.nonempty = 1'b1;
                        h.st.phase    = PH_BARE;
                    end else begin
                        h.emit     = 1'b1;
                        h.st.phase = PH_STOPPED;
                    end
                end
            end
            PH_QUOTED: begin
                if (c == CH_BSL) begin
                    if (eot) begin
                        h.st.nonempty = 1'b0;
                        h.emit        = 1'b1;
                        h.st.phase    = PH_STOPPED;
                    end else begin
                        h.st.phase = PH_ESCAPED;
                    end
                end else if (c == CH_QUOTE) begin
                    h.emit = 1'b1;
                    if (s.nonempty) begin
                        h.res.kind = K_ACCEPT;
                        h.st.phase = PH_KEY_SPACE;
                    end else begin
                        h.st.phase = PH_STOPPED;
                    end
                end else begin
                    h.emit        = 1'b1;
                    h.res.kind    = K_CHAR;
                    h.res.ch      = c;
                    h.st.nonempty = 1'b1;
                end
            end
            PH_ESCAPED: begin
                h.emit        = 1'b1;
                h.res.kind    = K_CHAR;
                h.res.ch      = c;
                h.st.nonempty = 1'b1;
                h.st.phase    = PH_QUOTED;
            end
            PH_BARE: begin
                h.emit = 1'b1;
                if (is_keych(c)) begin
                    h.res.kind = K_CHAR;
                    h.res.ch   = c;
                end else begin
                    h.res.kind = K_ACCEPT;
                    h.st.phase = PH_KEY_SPACE;
                    h.again    = 1'b1;
                end
            end
            default: begin
                h.st.phase = PH_STOPPED;
            end
        endcase
        return h;
    endfunction

    t_pst    r_st;
    t_pst    n_st;
    t_pst    s_mid;
    t_hstep  h1;
    t_hstep  h2;
    t_res    cand     [4];
    logic    cand_v   [4];
    logic [2:0] res_cnt;
    t_bundle bnd;
    logic    accept;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;

    // up to two looks at the character, then the end-of-text wrap-up
    always_comb begin
        h1    = handle(r_st, i_in.in_char, i_in.end_of_text);
        h2    = handle(h1.st, i_in.in_char, i_in.end_of_text);
        s_mid = h1.again ? h2.st : h1.st;

        cand[0]   = h1.res;
        cand_v[0] = h1.emit;
        cand[1]   = h2.res;
        cand_v[1] = h1.again && h2.emit;

        cand[2].kind   = K_DISCARD;
        cand[2].key_id = s_mid.cur_key;
        cand[2].ch     = 8'h00;
        cand_v[2]      = 1'b0;
        if (i_in.end_of_text) begin
            case (s_mid.phase) inside
                PH_KEY, PH_EQ_SPACE, PH_VALUE_SPACE: begin
                    cand_v[2] = 1'b1;
                end
                PH_QUOTED, PH_ESCAPED, PH_BARE: begin
                    cand_v[2]    = 1'b1;
                    cand[2].kind = s_mid.nonempty ? K_ACCEPT : K_DISCARD;
                end
                default: begin
                    cand_v[2] = 1'b0;
                end
            endcase
        end

        cand[3].kind   = K_DONE;
        cand[3].key_id = 1'b0;
        cand[3].ch     = 8'h00;
        cand_v[3]      = i_in.end_of_text;

        n_st = i_in.end_of_text ? PST_RESET : s_mid;
    end

    // pack the candidates into result slots, extras dropped
    always_comb begin
        bnd     = '0;
        res_cnt = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && res_cnt < 3'(RES_MAX)) begin
                bnd.res[res_cnt[1:0]] = cand[i];
                res_cnt               = res_cnt + 3'd1;
            end
        end
        bnd.cnt = res_cnt[1:0];
    end

    assign o_push   = accept && (res_cnt != 3'd0);
    assign o_bundle = bnd;

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= PST_RESET;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    // every text ends back at the start state
    a_eot_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.end_of_text |=> r_st == PST_RESET)
        else $error("parse state not restarted after end of text");

    // empty bundles never enter the queue
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_bundle.cnt != 2'd0)
        else $error("empty bundle pushed");

endmodule

>>> src/kvap_queue.sv
// ----------------------------------------------------------------------------
// kvap_queue
// Short first-in first-out queue of result bundles between parser and output.
// ----------------------------------------------------------------------------
module kvap_queue
    import kvap_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_ready,
    output logic    o_valid,
    output t_bundle o_head,
    input  logic    i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointer wrap
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= n_wr_ptr;
            if (i_pop)  r_rd_ptr <= n_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

>>> src/kvap_back.sv
// ----------------------------------------------------------------------------
// kvap_back
// Output side: walks the head bundle's results into an output register one
// per cycle while the output is taken, and flags each character's last result.
// ----------------------------------------------------------------------------
module kvap_back
    import kvap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_bundle    i_head,
    output logic       o_pop,
    kvap_out_if.source o_out
);

    logic [1:0] r_sub;
    logic       r_valid;
    t_res       r_res;
    logic       r_last;
    t_res       sel;
    logic       sel_last;
    logic       load_ok;

    // pick the current slot of the head bundle
    always_comb begin
        case (r_sub)
            2'd0:    sel = i_head.res[0];
            2'd1:    sel = i_head.res[1];
            default: sel = i_head.res[2];
        endcase
    end

    assign sel_last = (r_sub == i_head.cnt - 2'd1);
    assign load_ok  = !r_valid || o_out.ready;
    assign o_pop    = load_ok && i_q_valid && sel_last;

    // slot counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 2'd0;
            r_valid <= 1'b0;
        end else if (load_ok) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_sub <= sel_last ? 2'd0 : r_sub + 2'd1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load_ok && i_q_valid) begin
            r_res  <= sel;
            r_last <= sel_last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_res.kind;
    assign o_out.key_id      = r_res.key_id;
    assign o_out.out_char    = r_res.ch;
    assign o_out.last_result = r_last;

    a_sub_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> r_sub < i_head.cnt)
        else $error("result slot beyond bundle count");

endmodule

>>> src/key_value_attribute_parser.sv
// ----------------------------------------------------------------------------
// key_value_attribute_parser
// Top level: parser front end, bundle queue and result serializer.
// ----------------------------------------------------------------------------
// The block takes one character of an attribute text per cycle as long as its
// result queue (QUEUE_DEPTH bundles) has room, and produces one result per
// cycle at the output register while the output is taken. A character causes
// zero to three results; a character with at most one result therefore keeps
// up with one character per cycle, while one with more results holds the
// output for each of them, and the queue absorbs such bursts. An accepted
// character's first result passes through the queue and then the output
// register. Value characters come out tagged with their key, followed by a
// pair accepted or discarded result and, at the end of the text, a text
// finished result; the last result of each character carries last_result.
// ----------------------------------------------------------------------------
module key_value_attribute_parser
    import kvap_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvap_in_if.sink    i_in,
    kvap_out_if.source o_out
);

    logic    push;
    t_bundle push_bundle;
    logic    q_ready;
    logic    q_valid;
    t_bundle q_head;
    logic    pop;

    // classify characters and build result bundles
    kvap_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_bundle  (push_bundle)
    );

    // decouple parser and output
    kvap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .o_ready  (q_ready),
        .o_valid  (q_valid),
        .o_head   (q_head),
        .i_pop    (pop)
    );

    // deliver results one per transaction
    kvap_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
